// ===== design/shelf_atlas_packer_assert.svh =====
// ----------------------------------------------------------------------------
// shelf_atlas_packer assertion macros
// concurrent check helpers for the packer rtl
// ----------------------------------------------------------------------------
`ifndef SHELF_ATLAS_PACKER_ASSERT_SVH
`define SHELF_ATLAS_PACKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication under reset
`define SAP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shelf_atlas_packer: same-cycle check failed");

// next-cycle implication under reset
`define SAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shelf_atlas_packer: next-cycle check failed");

`else

`define SAP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SAP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/sap_pkg.sv =====
// ----------------------------------------------------------------------------
// sap_pkg
// widths, reset values and register indexes of the shelf atlas packer
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam int DEF_MAX_ROWS         = 256;
    localparam int DEF_MAX_GLYPH_HEIGHT = 128;

    localparam int FIELD_W   = 12;   // glyph and position fields
    localparam int REG_W     = 13;   // atlas sizes, row fill and top
    localparam int CFG_IDX_W = 4;

    localparam logic [REG_W-1:0] ATLAS_WIDTH_RST  = 13'd2048;
    localparam logic [REG_W-1:0] ATLAS_HEIGHT_RST = 13'd2048;
    localparam logic [REG_W-1:0] TOP_MAX          = 13'h1FFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATLAS_WIDTH  = 4'd0,
        CFG_ATLAS_HEIGHT = 4'd1
    } cfg_index_t;

endpackage

// ===== design/shelf_atlas_packer.sv =====
// ----------------------------------------------------------------------------
// shelf_atlas_packer
// shelf packing of rectangles into a 2-d atlas with a row memory
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request word: glyph width and height. m_axis returns one
//   result word per request: placed flag, x, y and the opened-row flag.
//   cfg_* writes atlas_width (index 0) or atlas_height (index 1); cfg_ready is
//   always high, writes are meant to happen while the block is idle.
// timing:
//   a too-tall request goes straight to the result; any other request scans
//   the stored rows and opens a new row when none takes it. a new request is
//   accepted only after the last result leaves for the output register. rows
//   are read one per cycle through the single read port, which sets the scan time.
// reset:
//   aresetn (synchronous, active low) empties the row store, clears the
//   running top and restores both atlas sizes to 2048. the row memory needs
//   no clearing pass since only rows below the row count are read.
// stall:
//   the result sits in an output register; a new request is accepted while
//   it waits, and the next result holds in the block until the register frees.
// ----------------------------------------------------------------------------
module shelf_atlas_packer
    import sap_pkg::*;
#(
    parameter int MAX_ROWS         = DEF_MAX_ROWS,
    parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // glyph_width[11:0], glyph_height[23:12]

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // placed[0], pos_x[12:1], pos_y[24:13],
                                                 // opened_row[25], zero[31:26]

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [REG_W-1:0]     cfg_wdata
);

    localparam int IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W  = $clog2(MAX_ROWS + 1);
    localparam int BAND_W = $clog2(MAX_GLYPH_HEIGHT + 8);
    localparam int ROW_W  = 2 * REG_W + BAND_W;

    localparam logic [CNT_W-1:0]   ROWS_LIM    = CNT_W'(MAX_ROWS);
    localparam logic [FIELD_W-1:0] GLYPH_H_LIM = FIELD_W'(MAX_GLYPH_HEIGHT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OPEN,
        ST_RESULT
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [FIELD_W-1:0]   w_reg, w_next;
    logic [FIELD_W-1:0]   h_reg, h_next;
    logic [BAND_W-1:0]    band_reg, band_next;
    logic [CNT_W-1:0]     row_count_reg, row_count_next;
    logic [REG_W-1:0]     next_top_reg, next_top_next;
    logic [REG_W-1:0]     atlas_w_reg, atlas_w_next;
    logic [REG_W-1:0]     atlas_h_reg, atlas_h_next;

    logic                 res_placed_reg, res_placed_next;
    logic [FIELD_W-1:0]   res_x_reg, res_x_next;
    logic [FIELD_W-1:0]   res_y_reg, res_y_next;
    logic                 res_opened_reg, res_opened_next;

    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          m_data_reg, m_data_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ROW_W-1:0]     ram_rdata;

    logic                 in_accept;
    logic [FIELD_W-1:0]   h_in;
    logic [REG_W-1:0]     band_full;
    logic                 too_tall;

    logic [REG_W-1:0]     rd_top;
    logic [BAND_W-1:0]    rd_band;
    logic [REG_W-1:0]     rd_fill;
    logic [REG_W:0]       fit_sum;
    logic                 row_hit;
    logic                 last_row;

    logic [REG_W:0]       open_sum;
    logic [REG_W:0]       top_sum;
    logic [REG_W-1:0]     top_sat;
    logic                 open_ok;

    sap_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ROWS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // band rounding of the incoming height
    assign h_in      = s_axis_tdata[23:12];
    assign band_full = ({1'b0, h_in} + 13'd8) & ~13'd7;
    assign too_tall  = (h_in >= GLYPH_H_LIM);

    // row word: {top, band, fill}
    assign rd_top   = ram_rdata[ROW_W-1 -: REG_W];
    assign rd_band  = ram_rdata[REG_W +: BAND_W];
    assign rd_fill  = ram_rdata[REG_W-1:0];
    assign fit_sum  = {1'b0, rd_fill} + {2'b00, w_reg};
    assign row_hit  = (rd_band == band_reg) && (fit_sum < {1'b0, atlas_w_reg});
    assign last_row = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == row_count_reg);

    assign open_sum = {1'b0, next_top_reg} + {2'b00, h_reg};
    assign top_sum  = {1'b0, next_top_reg} + (REG_W + 1)'(band_reg);
    assign top_sat  = top_sum[REG_W] ? TOP_MAX : top_sum[REG_W-1:0];
    assign open_ok  = (row_count_reg < ROWS_LIM)
                   && (open_sum < {1'b0, atlas_h_reg})
                   && ({1'b0, w_reg} < atlas_w_reg);

    always_comb begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        band_next       = band_reg;
        row_count_next  = row_count_reg;
        next_top_next   = next_top_reg;
        atlas_w_next    = atlas_w_reg;
        atlas_h_next    = atlas_h_reg;
        res_placed_next = res_placed_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_opened_next = res_opened_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;

        ram_we    = 1'b0;
        ram_waddr = scan_idx_reg;
        ram_wdata = {rd_top, rd_band, fit_sum[REG_W-1:0] + 13'd1};
        ram_raddr = (state_reg == ST_SCAN) ? (scan_idx_reg + IDX_W'(1)) : '0;

        if (cfg_valid) begin
            case (cfg_addr)
                CFG_ATLAS_WIDTH:  atlas_w_next = cfg_wdata;
                CFG_ATLAS_HEIGHT: atlas_h_next = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    w_next          = s_axis_tdata[11:0];
                    h_next          = h_in;
                    band_next       = band_full[BAND_W-1:0];
                    scan_idx_next   = '0;
                    res_placed_next = 1'b0;
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_opened_next = 1'b0;
                    if (too_tall) begin
                        state_next = ST_RESULT;
                    end else if (row_count_reg == '0) begin
                        state_next = ST_OPEN;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read data belongs to scan_idx_reg, next row already requested
                if (row_hit) begin
                    ram_we          = 1'b1;
                    res_placed_next = 1'b1;
                    res_x_next      = rd_fill[FIELD_W-1:0];
                    res_y_next      = rd_top[FIELD_W-1:0];
                    state_next      = ST_RESULT;
                end else if (last_row) begin
                    state_next = ST_OPEN;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_OPEN: begin
                if (open_ok) begin
                    ram_we          = 1'b1;
                    ram_waddr       = row_count_reg[IDX_W-1:0];
                    ram_wdata       = {next_top_reg, band_reg,
                                       {1'b0, w_reg} + 13'd1};
                    row_count_next  = row_count_reg + CNT_W'(1);
                    next_top_next   = top_sat;
                    res_placed_next = 1'b1;
                    res_y_next      = next_top_reg[FIELD_W-1:0];
                    res_opened_next = 1'b1;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, res_opened_reg, res_y_reg, res_x_reg,
                                    res_placed_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_count_reg <= '0;
            next_top_reg  <= '0;
            atlas_w_reg   <= ATLAS_WIDTH_RST;
            atlas_h_reg   <= ATLAS_HEIGHT_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            next_top_reg  <= next_top_next;
            atlas_w_reg   <= atlas_w_next;
            atlas_h_reg   <= atlas_h_next;
            m_valid_reg   <= m_valid_next;
        end
        scan_idx_reg   <= scan_idx_next;
        w_reg          <= w_next;
        h_reg          <= h_next;
        band_reg       <= band_next;
        res_placed_reg <= res_placed_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_opened_reg <= res_opened_next;
        m_data_reg     <= m_data_next;
    end

    `include "shelf_atlas_packer_assert.svh"

    `SAP_ASSERT_IMPLIES(a_row_count_bound, aclk, aresetn, 1'b1, row_count_reg <= ROWS_LIM)
    `SAP_ASSERT_NEXT(a_accept_busy, aclk, aresetn, in_accept, state_reg != ST_IDLE)
    `SAP_ASSERT_NEXT(a_open_count, aclk, aresetn, (state_reg == ST_OPEN) && open_ok, row_count_reg == $past(row_count_reg) + CNT_W'(1))
    `SAP_ASSERT_NEXT(a_result_hold, aclk, aresetn, (state_reg == ST_RESULT) && m_valid_reg && !m_axis_tready, state_reg == ST_RESULT)

endmodule

// ===== design/sap_ram.sv =====
// ----------------------------------------------------------------------------
// sap_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module sap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for shelf_atlas_packer: a directed table of glyph
// requests, then random requests over several atlas sizes, each result word
// compared field by field with the typed expected word of a directed case
// where there is one, else with an in-bench model of the shelf store
module tb_top;
    import sap_pkg::*;

    localparam int MAX_SHELVES   = DEF_MAX_ROWS;
    localparam int MAX_GLYPH_H   = DEF_MAX_GLYPH_HEIGHT;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = DEF_MAX_ROWS + 8;
    localparam int STALL_LIMIT   = 5000;

    typedef struct packed {
        logic        placed;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic        opened_row;
    } placement_t;

    typedef struct packed {
        logic [11:0] w;
        logic [11:0] h;
        logic        typed;
        placement_t  want;
    } glyph_case_t;

    localparam placement_t REFUSED = '{1'b0, 12'd0, 12'd0, 1'b0};

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;   // glyph_width[11:0], glyph_height[23:12]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;         // placed[0], pos_x[12:1], pos_y[24:13],
                                                // opened_row[25], zero[31:26]
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    cfg_index_t           cfg_addr      = CFG_ATLAS_WIDTH;
    logic [REG_W-1:0]     cfg_wdata     = '0;

    // shelf store as the bench sees it
    logic [12:0] shelf_top  [MAX_SHELVES];
    logic [7:0]  shelf_band [MAX_SHELVES];
    logic [12:0] shelf_fill [MAX_SHELVES];
    int          shelf_count    = 0;
    logic [12:0] shelf_next_top = '0;
    logic [12:0] atlas_w        = ATLAS_WIDTH_RST;
    logic [12:0] atlas_h        = ATLAS_HEIGHT_RST;

    placement_t expected_placements [$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;

    glyph_case_t directed_cases [21] = '{
        '{12'd10,   12'd5,    1'b1, '{1'b1, 12'd0,  12'd0, 1'b1}},  // first row opens
        '{12'd0,    12'd0,    1'b1, '{1'b1, 12'd11, 12'd0, 1'b0}},  // zero width shares it
        '{12'd4095, 12'd127,  1'b1, REFUSED},                        // too wide for a new row
        '{12'd0,    12'd128,  1'b1, REFUSED},                        // height at the limit
        '{12'd4095, 12'd4095, 1'b1, REFUSED},
        '{12'd2047, 12'd127,  1'b1, '{1'b1, 12'd0,  12'd8, 1'b1}},  // top kept after refusal
        '{12'd0,    12'd120,  1'b0, REFUSED},
        '{12'd2046, 12'd8,    1'b0, REFUSED},
        '{12'd0,    12'd15,   1'b0, REFUSED},
        '{12'd0,    12'd15,   1'b0, REFUSED},
        '{12'hAAA,  12'h055,  1'b0, REFUSED},
        '{12'h555,  12'h02A,  1'b0, REFUSED},
        '{12'h2AA,  12'h07F,  1'b0, REFUSED},
        '{12'd1,    12'd127,  1'b0, REFUSED},
        '{12'd700,  12'd42,   1'b0, REFUSED},
        '{12'd700,  12'd47,   1'b0, REFUSED},
        '{12'd700,  12'd40,   1'b0, REFUSED},
        '{12'd1,    12'd1,    1'b0, REFUSED},
        '{12'd2047, 12'd1,    1'b0, REFUSED},
        '{12'd0,    12'hF80,  1'b1, REFUSED},
        '{12'd3,    12'h07F,  1'b0, REFUSED}
    };

    shelf_atlas_packer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic placement_t place_glyph(input logic [11:0] w, input logic [11:0] h);
        placement_t res;
        int         band;
        int         grown;
        res = REFUSED;
        if (int'(h) >= MAX_GLYPH_H) begin
            return res;
        end
        band = (int'(h) + 8) & ~7;
        // first shelf of the same band with room strictly below the width
        for (int i = 0; i < shelf_count; i++) begin
            if (int'(shelf_band[i]) == band
                    && int'(shelf_fill[i]) + int'(w) < int'(atlas_w)) begin
                res.placed = 1'b1;
                res.pos_x  = shelf_fill[i][11:0];
                res.pos_y  = shelf_top[i][11:0];
                shelf_fill[i] = 13'(int'(shelf_fill[i]) + int'(w) + 1);
                return res;
            end
        end
        if (shelf_count < MAX_SHELVES
                && int'(shelf_next_top) + int'(h) < int'(atlas_h)
                && int'(w) < int'(atlas_w)) begin
            shelf_top[shelf_count]  = shelf_next_top;
            shelf_band[shelf_count] = 8'(band);
            shelf_fill[shelf_count] = 13'(int'(w) + 1);
            shelf_count++;
            res.placed     = 1'b1;
            res.pos_y      = shelf_next_top[11:0];
            res.opened_row = 1'b1;
            grown = int'(shelf_next_top) + band;
            shelf_next_top = (grown > int'(TOP_MAX)) ? TOP_MAX : 13'(grown);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        placement_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_placements.size() == 0) begin
                report_mismatch("result word with no request pending", int'(m_axis_tdata), 0);
            end else begin
                want = expected_placements.pop_front();
                if (m_axis_tdata[0] !== want.placed)
                    report_mismatch("placed", int'(m_axis_tdata[0]), int'(want.placed));
                if (m_axis_tdata[12:1] !== want.pos_x)
                    report_mismatch("pos_x", int'(m_axis_tdata[12:1]), int'(want.pos_x));
                if (m_axis_tdata[24:13] !== want.pos_y)
                    report_mismatch("pos_y", int'(m_axis_tdata[24:13]), int'(want.pos_y));
                if (m_axis_tdata[25] !== want.opened_row)
                    report_mismatch("opened_row", int'(m_axis_tdata[25]),
                                    int'(want.opened_row));
            end
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // tvalid stays high from one word to the next unless a gap is drawn
    task automatic send_glyph(input logic [11:0] w, input logic [11:0] h,
                              input logic typed, input placement_t typed_want);
        placement_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tdata  <= {h, w};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = place_glyph(w, h);
        if (typed)
            predicted = typed_want;
        expected_placements = {expected_placements, predicted};
    endtask

    task automatic wait_for_placements();
        s_axis_tvalid <= 1'b0;
        while (expected_placements.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_atlas(input logic [12:0] width_px, input logic [12:0] height_px);
        cfg_addr  <= CFG_ATLAS_WIDTH;
        cfg_wdata <= width_px;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        atlas_w = width_px;
        cfg_addr  <= CFG_ATLAS_HEIGHT;
        cfg_wdata <= height_px;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        atlas_h = height_px;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_glyphs(input int count);
        logic [11:0] w;
        logic [11:0] h;
        int          pick;
        int          span;
        repeat (count) begin
            pick = $urandom_range(99);
            span = (int'(atlas_w) > 4095) ? 4095 : int'(atlas_w);
            // mostly a few narrow bands so shelves get reused
            h = 12'(8 * $urandom_range(3, 0) + $urandom_range(7, 0));
            w = 12'($urandom_range(span / 3, 0));
            if (pick < 10) begin
                w = 12'($urandom);
                h = 12'($urandom_range(4095, MAX_GLYPH_H));
            end else if (pick < 25) begin
                w = 12'($urandom);
                h = 12'($urandom_range(MAX_GLYPH_H - 1, 0));
            end else if (pick < 35) begin
                // right at the fill limit
                w = (span > 3) ? 12'(span - int'($urandom_range(3, 0))) : 12'd0;
            end
            send_glyph(w, h, 1'b0, REFUSED);
        end
    endtask

    // every word opens a shelf until the store or the atlas height runs out
    task automatic send_wide_glyphs(input int count);
        repeat (count) begin
            send_glyph(12'(int'(atlas_w) - 1), 12'($urandom_range(7, 0)), 1'b0, REFUSED);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 79;
        foreach (directed_cases[i]) begin
            send_glyph(directed_cases[i].w, directed_cases[i].h,
                       directed_cases[i].typed, directed_cases[i].want);
        end

        wait_for_placements();
        set_atlas(13'd4096, 13'd4096);
        send_random_glyphs(60);
        wait_for_placements();
        send_random_glyphs(60);

        wait_for_placements();
        set_atlas(13'd0, 13'd0);
        send_random_glyphs(10);

        wait_for_placements();
        set_atlas(13'd1, 13'h1FFF);
        send_random_glyphs(15);

        send_idle_pct = 79;
        recv_idle_pct = 28;
        wait_for_placements();
        set_atlas(13'd700, 13'd3000);
        send_random_glyphs(120);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_for_placements();
        set_atlas(13'd4096, 13'h1FFF);
        send_wide_glyphs(230);
        send_random_glyphs(40);

        wait_for_placements();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/sap_pkg.sv
design/sap_ram.sv
design/shelf_atlas_packer.sv
tb/sv/tb_top.sv
